@@ rtl/ajf_pkg.sv @@
package ajf_pkg;

  localparam int FIFO_DEPTH = 65536;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);
  localparam int SAMPLE_W   = 32;
  localparam int LEN_W      = 17;
  localparam int CMP_W      = (LVL_W > LEN_W) ? LVL_W : LEN_W;

  localparam logic [LEN_W-1:0] PREBUF_RESET = LEN_W'(48000);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_PLAY  = 2'd1,
    OP_END   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_PRIMED    = 2'd1,
    EV_RECOVERED = 2'd2,
    EV_UNDERRUN  = 2'd3
  } ev_t;

  // Result fields known once the control update is done
  typedef struct packed {
    logic             from_fifo;
    logic             accepted;
    ev_t              event_code;
    logic [31:0]      underruns;
    logic [LEN_W-1:0] fill;
    logic             playing;
  } res_meta_t;

  // Sample store access issued by the control update
  typedef struct packed {
    logic                we;
    logic [PTR_W-1:0]    waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic                re;
    logic [PTR_W-1:0]    raddr;
  } mem_req_t;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

endpackage

@@ rtl/ajf_channels.sv @@
interface ajf_in_if;
  import ajf_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [SAMPLE_W-1:0] sample_in;
  logic [LEN_W-1:0]    frame_length;

  modport source (output valid, output opcode, output sample_in, output frame_length,
                  input ready);
  modport sink (input valid, input opcode, input sample_in, input frame_length,
                output ready);
endinterface

interface ajf_out_if;
  import ajf_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_out;
  logic                sample_from_fifo;
  logic                write_accepted;
  logic [1:0]          status_event;
  logic [31:0]         underrun_count;
  logic [LEN_W-1:0]    fill_level;
  logic                is_playing;

  modport source (output valid, output sample_out, output sample_from_fifo,
                  output write_accepted, output status_event, output underrun_count,
                  output fill_level, output is_playing, input ready);
  modport sink (input valid, input sample_out, input sample_from_fifo,
                input write_accepted, input status_event, input underrun_count,
                input fill_level, input is_playing, output ready);
endinterface

@@ rtl/ajf_sample_ram.sv @@
module ajf_sample_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/ajf_ctrl.sv @@
module ajf_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic [1:0]                   opcode,
  input  logic [ajf_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [ajf_pkg::LEN_W-1:0]    frame_length,
  input  logic                         cfg_wr_en,
  input  logic [ajf_pkg::LEN_W-1:0]    cfg_wr_data,
  output ajf_pkg::res_meta_t           meta,
  output ajf_pkg::mem_req_t            mem
);
  import ajf_pkg::*;

  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             playing_r, playing_nxt;
  logic             started_r, started_nxt;
  logic             done_r, done_nxt;
  logic             dropping_r, dropping_nxt;
  logic [31:0]      underruns_r, underruns_nxt;
  logic [LEN_W-1:0] prebuf_r;

  logic             wr, rd, accepted, from_fifo, store, start, play_v, full, nonempty;
  logic [CMP_W-1:0] free_space;
  ev_t              ev;

  assign full       = (level_r == LVL_W'(FIFO_DEPTH));
  assign nonempty   = (level_r != '0);
  assign free_space = CMP_W'(FIFO_DEPTH) - CMP_W'(level_r);

  always_comb begin
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    level_nxt     = level_r;
    playing_nxt   = playing_r;
    started_nxt   = started_r;
    done_nxt      = done_r;
    dropping_nxt  = dropping_r;
    underruns_nxt = underruns_r;
    wr            = 1'b0;
    rd            = 1'b0;
    accepted      = 1'b0;
    from_fifo     = 1'b0;
    store         = 1'b0;
    start         = 1'b0;
    play_v        = 1'b0;
    ev            = EV_NONE;
    case (opcode)
      OP_WRITE: begin
        store = 1'b1;
        if (frame_length != '0) begin
          dropping_nxt = (free_space < CMP_W'(frame_length));
          store        = !dropping_nxt;
        end else if (dropping_r) begin
          store = 1'b0;
        end
        if (store && !full) begin
          wr        = 1'b1;
          accepted  = 1'b1;
          wptr_nxt  = ptr_adv(wptr_r);
          level_nxt = LVL_W'(level_r + 1'b1);
        end
      end
      OP_PLAY: begin
        start = !playing_r &&
                ((CMP_W'(level_r) >= CMP_W'(prebuf_r)) || (done_r && nonempty));
        play_v = playing_r || start;
        if (start) begin
          ev          = started_r ? EV_RECOVERED : EV_PRIMED;
          started_nxt = 1'b1;
          playing_nxt = 1'b1;
        end
        if (play_v && nonempty) begin
          rd        = 1'b1;
          from_fifo = 1'b1;
          rptr_nxt  = ptr_adv(rptr_r);
          level_nxt = LVL_W'(level_r - 1'b1);
        end else if (play_v && !done_r) begin
          playing_nxt   = 1'b0;
          underruns_nxt = underruns_r + 32'd1;
          ev            = EV_UNDERRUN;
        end
      end
      OP_END: begin
        done_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r      <= '0;
      rptr_r      <= '0;
      level_r     <= '0;
      playing_r   <= 1'b0;
      started_r   <= 1'b0;
      done_r      <= 1'b0;
      dropping_r  <= 1'b0;
      underruns_r <= '0;
    end else if (acc) begin
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      level_r     <= level_nxt;
      playing_r   <= playing_nxt;
      started_r   <= started_nxt;
      done_r      <= done_nxt;
      dropping_r  <= dropping_nxt;
      underruns_r <= underruns_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prebuf_r <= PREBUF_RESET;
    end else if (cfg_wr_en) begin
      prebuf_r <= cfg_wr_data;
    end
  end

  always_comb begin
    meta.from_fifo  = from_fifo;
    meta.accepted   = accepted;
    meta.event_code = ev;
    meta.underruns  = underruns_nxt;
    meta.fill       = LEN_W'(level_nxt);
    meta.playing    = playing_nxt;
    mem.we          = acc && wr;
    mem.waddr       = wptr_r;
    mem.wdata       = sample_in;
    mem.re          = acc && rd;
    mem.raddr       = rptr_r;
  end

endmodule

@@ rtl/ajf_out_pipe.sv @@
module ajf_out_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  ajf_pkg::res_meta_t           meta,
  input  logic [ajf_pkg::SAMPLE_W-1:0] rdata,
  output logic                         take,
  ajf_out_if.source                    res
);
  import ajf_pkg::*;

  logic                s1_v_r, s1_v_nxt;
  res_meta_t           s1_meta_r;
  logic                s2_v_r, s2_v_nxt;
  res_meta_t           s2_meta_r;
  logic [SAMPLE_W-1:0] s2_sample_r;
  logic                s2_free, move;

  assign s2_free = !s2_v_r || res.ready;
  assign move    = s1_v_r && s2_free;
  assign take    = !s1_v_r || s2_free;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (acc) begin
      s1_v_nxt = 1'b1;
    end else if (move) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (move) begin
      s2_v_nxt = 1'b1;
    end else if (res.ready) begin
      s2_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_meta_r <= meta;
    end
    if (move) begin
      s2_meta_r   <= s1_meta_r;
      s2_sample_r <= s1_meta_r.from_fifo ? rdata : '0;
    end
  end

  assign res.valid            = s2_v_r;
  assign res.sample_out       = s2_sample_r;
  assign res.sample_from_fifo = s2_meta_r.from_fifo;
  assign res.write_accepted   = s2_meta_r.accepted;
  assign res.status_event     = s2_meta_r.event_code;
  assign res.underrun_count   = s2_meta_r.underruns;
  assign res.fill_level       = s2_meta_r.fill;
  assign res.is_playing       = s2_meta_r.playing;

endmodule

@@ rtl/audio_playout_jitter_fifo_unit.sv @@
// Audio playout jitter FIFO with prebuffer.
// in_req carries one request per item: write a sample (optionally opening a
// frame that is dropped whole when it will not fit), play one sample, or mark
// the end of input. out_res returns exactly one result per request, in order:
// the played word, flags, status event, underrun count, fill level and
// playing state after that request.
// cfg_wr_en/cfg_wr_data set the prebuffer level; write it only while idle.
// Throughput: one request per cycle while out_res is not stalled. Pointers,
// level and flags are updated in the accept cycle, and the sample store (one
// write port, one registered read port) is touched once per request, so no
// two accesses ever collide. A result passes the store read register and the
// first result stage, then the output register.
// A stalled out_res holds its result; one more result waits behind it, so
// in_req.ready falls only while both stages are full and the output stalls.
// Reset: pointers, level, flags and the underrun count clear synchronously;
// the prebuffer level returns to 48000. The store needs no clearing pass,
// since only written entries are ever read.
module audio_playout_jitter_fifo_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  ajf_in_if.sink                    in_req,
  ajf_out_if.source                 out_res,
  input  logic                      cfg_wr_en,
  input  logic [ajf_pkg::LEN_W-1:0] cfg_wr_data
);
  import ajf_pkg::*;

  logic                acc;
  logic                take;
  res_meta_t           meta;
  mem_req_t            mem;
  logic [SAMPLE_W-1:0] rdata;

  // Accept a request whenever the first result stage is free or draining
  assign in_req.ready = take;
  assign acc          = in_req.valid && take;

  ajf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .opcode       (in_req.opcode),
    .sample_in    (in_req.sample_in),
    .frame_length (in_req.frame_length),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .meta         (meta),
    .mem          (mem)
  );

  // Sample store: a write lands at the edge before any later read of it
  ajf_sample_ram #(
    .DEPTH (FIFO_DEPTH),
    .AW    (PTR_W),
    .DW    (SAMPLE_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  ajf_out_pipe u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .meta  (meta),
    .rdata (rdata),
    .take  (take),
    .res   (out_res)
  );

  // A result not read from the store plays silence
  a_silence: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.sample_from_fifo) |-> (out_res.sample_out == '0))
    else $error("non-zero sample without a store read");

  // An underrun always leaves playout stopped
  a_underrun_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.status_event == EV_UNDERRUN) |-> !out_res.is_playing)
    else $error("underrun reported while still playing");

  // Back-pressure only ever comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> (out_res.valid && !out_res.ready))
    else $error("input stalled without output stall");

  // Only a write request can be reported as stored
  a_accept_write: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && meta.accepted) |-> (in_req.opcode == OP_WRITE))
    else $error("store reported for a non-write request");

endmodule

@@ tb/audio_playout_jitter_fifo_unit_tb.sv @@
module audio_playout_jitter_fifo_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ajf_pkg::*;

  // Opcode 3 has no meaning: the block must leave its state alone
  localparam logic [1:0] OP_UNDEF = 2'd3;

  // Cycles to let pass after the last result before touching the register
  localparam int SETTLE_CYCLES = 4;
  // Receiver hold-off used to back the block up and stall its input
  localparam int LONG_HOLD     = 64;
  // Cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT   = 5000;
  localparam int SHOWN_ERRORS  = 10;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                from_fifo;
    logic                accepted;
    ev_t                 event_code;
    logic [31:0]         underruns;
    logic [LEN_W-1:0]    fill;
    logic                playing;
  } playout_result_t;

  // One line of the directed table; arg is frame_length or the new prebuffer level
  typedef struct packed {
    row_kind_t        kind;
    logic [1:0]       op;
    logic [31:0]      sample;
    logic [LEN_W-1:0] arg;
    logic             typed;
    playout_result_t  res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  ajf_in_if  in_ch ();
  ajf_out_if out_ch ();

  audio_playout_jitter_fifo_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_ch),
    .out_res     (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the playout FIFO
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] pcm_store [FIFO_DEPTH];
  int                  wr_idx;
  int                  rd_idx;
  int                  fifo_level;
  bit                  running;
  bit                  ever_primed;
  bit                  end_marked;
  bit                  dropping_frame;
  logic [31:0]         underrun_total;
  logic [LEN_W-1:0]    prebuffer_q;

  // Expected results, oldest first
  playout_result_t pending_results [$];
  stim_row_t       row_table [$];

  int fail_count;
  int stall_cycles;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  // Apply one request to the shadow state and return what the block must report
  function automatic playout_result_t predict_playout(input logic [1:0] op,
                                                      input logic [31:0] smp,
                                                      input logic [LEN_W-1:0] flen);
    playout_result_t r;
    bit store_it;
    r = '0;
    r.event_code = EV_NONE;
    case (op)
      OP_WRITE: begin
        store_it = 1'b1;
        if (flen != '0) begin
          // A frame start decides the fate of the whole frame
          dropping_frame = (int'(flen) > (FIFO_DEPTH - fifo_level));
          store_it = !dropping_frame;
        end else if (dropping_frame) begin
          store_it = 1'b0;
        end
        if (store_it && fifo_level < FIFO_DEPTH) begin
          pcm_store[wr_idx] = smp;
          wr_idx = (wr_idx == FIFO_DEPTH - 1) ? 0 : wr_idx + 1;
          fifo_level++;
          r.accepted = 1'b1;
        end
      end
      OP_PLAY: begin
        if (!running && (fifo_level >= int'(prebuffer_q) || (end_marked && fifo_level > 0))) begin
          r.event_code = ever_primed ? EV_RECOVERED : EV_PRIMED;
          ever_primed = 1'b1;
          running = 1'b1;
        end
        if (running && fifo_level > 0) begin
          r.sample = pcm_store[rd_idx];
          rd_idx = (rd_idx == FIFO_DEPTH - 1) ? 0 : rd_idx + 1;
          fifo_level--;
          r.from_fifo = 1'b1;
        end else if (running && !end_marked) begin
          running = 1'b0;
          underrun_total = underrun_total + 32'd1;
          r.event_code = EV_UNDERRUN;
        end
      end
      OP_END: end_marked = 1'b1;
      default: ;
    endcase
    r.underruns = underrun_total;
    r.fill = fifo_level[LEN_W-1:0];
    r.playing = running;
    return r;
  endfunction

  function automatic playout_result_t mk_result(input logic [31:0] s, input logic f,
                                                input logic a, input ev_t e,
                                                input logic [31:0] u,
                                                input logic [LEN_W-1:0] l, input logic p);
    playout_result_t r;
    r.sample = s;
    r.from_fifo = f;
    r.accepted = a;
    r.event_code = e;
    r.underruns = u;
    r.fill = l;
    r.playing = p;
    return r;
  endfunction

  function automatic void add_req(input logic [1:0] op, input logic [31:0] s,
                                  input logic [LEN_W-1:0] flen);
    row_table.push_back('{ROW_REQ, op, s, flen, 1'b0, '0});
  endfunction

  function automatic void add_req_checked(input logic [1:0] op, input logic [31:0] s,
                                          input logic [LEN_W-1:0] flen,
                                          input playout_result_t res);
    row_table.push_back('{ROW_REQ, op, s, flen, 1'b1, res});
  endfunction

  function automatic void add_cfg(input logic [LEN_W-1:0] lvl);
    row_table.push_back('{ROW_CFG, OP_UNDEF, 32'd0, lvl, 1'b0, '0});
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one request, hold it until taken, then log its expected result.
  // Entered and left just after a falling edge.
  task automatic send_request(input logic [1:0] op, input logic [31:0] smp,
                              input logic [LEN_W-1:0] flen, input bit typed,
                              input playout_result_t typed_res);
    int gap;
    playout_result_t pr;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.sample_in    <= smp;
    in_ch.frame_length <= flen;
    do @(posedge clk); while (!in_ch.ready);
    pr = predict_playout(op, smp, flen);
    pending_results.push_back(typed ? typed_res : pr);
    @(negedge clk);
  endtask

  // Stop offering, wait for every outstanding result, then let the pipe settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the prebuffer level; only called once the block is idle
  task automatic set_prebuffer(input logic [LEN_W-1:0] lvl);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lvl;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    prebuffer_q = lvl;
  endtask

  task automatic run_rows(input int first, input int last);
    for (int i = first; i <= last; i++) begin
      if (row_table[i].kind == ROW_CFG) begin
        drain_results();
        set_prebuffer(row_table[i].arg);
      end else begin
        send_request(row_table[i].op, row_table[i].sample, row_table[i].arg,
                     row_table[i].typed, row_table[i].res);
      end
    end
  endtask

  // Mostly whole frames and bursts of playout, with stray writes and
  // undefined opcodes as noise; undefined opcodes do not count toward the target
  task automatic random_phase(input int target);
    int done_cnt;
    int pick;
    int n;
    logic [LEN_W-1:0] flen;
    done_cnt = 0;
    while (done_cnt < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // Whole frame: start word carries the length, the rest continue it
        n = $urandom_range(1, 10);
        case ($urandom_range(0, 7))
          0:       flen = LEN_W'($urandom_range(0, 17'h1FFFF));
          1:       flen = LEN_W'($urandom_range(FIFO_DEPTH - 16, FIFO_DEPTH + 16));
          default: flen = LEN_W'(n);
        endcase
        if (flen == '0) flen = LEN_W'(1);
        send_request(OP_WRITE, $urandom, flen, 1'b0, '0);
        for (int k = 1; k < n; k++) send_request(OP_WRITE, $urandom, '0, 1'b0, '0);
        done_cnt += n;
      end else if (pick < 90) begin
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++)
          send_request(OP_PLAY, $urandom, LEN_W'($urandom_range(0, 17'h1FFFF)), 1'b0, '0);
        done_cnt += n;
      end else if (pick < 95) begin
        // Broken sequence: a continuation with no fresh frame start
        send_request(OP_WRITE, $urandom, '0, 1'b0, '0);
        done_cnt++;
      end else begin
        send_request(OP_UNDEF, $urandom, LEN_W'($urandom_range(0, 17'h1FFFF)), 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: per-result hold-off, plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : result_taker
    int gap;
    bit hold_seen;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_seen) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      hold_seen = hold_req;
      gap = rx_idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // Compare every taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    playout_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        if (fail_count < SHOWN_ERRORS)
          $display("%0t: unexpected result, sample=%h fill=%0d", $realtime,
                   out_ch.sample_out, out_ch.fill_level);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.sample_out !== want.sample || out_ch.sample_from_fifo !== want.from_fifo ||
            out_ch.write_accepted !== want.accepted ||
            out_ch.status_event !== want.event_code ||
            out_ch.underrun_count !== want.underruns || out_ch.fill_level !== want.fill ||
            out_ch.is_playing !== want.playing) begin
          if (fail_count < SHOWN_ERRORS) begin
            $display("%0t: mismatch exp: smp=%h ff=%0d acc=%0d ev=%0d und=%0d fill=%0d play=%0d",
                     $realtime, want.sample, want.from_fifo, want.accepted, want.event_code,
                     want.underruns, want.fill, want.playing);
            $display("%0t:          got: smp=%h ff=%0d acc=%0d ev=%0d und=%0d fill=%0d play=%0d",
                     $realtime, out_ch.sample_out, out_ch.sample_from_fifo,
                     out_ch.write_accepted, out_ch.status_event, out_ch.underrun_count,
                     out_ch.fill_level, out_ch.is_playing);
          end
          fail_count++;
        end
      end
    end
  end

  // Hang detector: count cycles in which neither side moves a request
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int head_rows;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_WRITE;
    in_ch.sample_in    = '0;
    in_ch.frame_length = '0;
    tx_idle_on         = 1'b1;
    rx_idle_on         = 1'b1;
    hold_req           = 1'b0;
    wr_idx             = 0;
    rd_idx             = 0;
    fifo_level         = 0;
    running            = 1'b0;
    ever_primed        = 1'b0;
    end_marked         = 1'b0;
    dropping_frame     = 1'b0;
    underrun_total     = '0;
    prebuffer_q        = PREBUF_RESET;

    // Opening rows: reset state, field extremes, frame keep/drop, underruns
    add_req_checked(OP_PLAY, 32'hFFFF_FFFF, 17'h1FFFF,
                    mk_result('0, 1'b0, 1'b0, EV_NONE, '0, '0, 1'b0));
    add_req_checked(OP_UNDEF, 32'hFFFF_FFFF, 17'h1FFFF,
                    mk_result('0, 1'b0, 1'b0, EV_NONE, '0, '0, 1'b0));
    add_req_checked(OP_WRITE, 32'hFFFF_FFFF, '0,
                    mk_result('0, 1'b0, 1'b1, EV_NONE, '0, 17'd1, 1'b0));
    // frame longer than the whole store: dropped
    add_req_checked(OP_WRITE, 32'h0000_0000, 17'h1FFFF,
                    mk_result('0, 1'b0, 1'b0, EV_NONE, '0, 17'd1, 1'b0));
    // continuation of a dropped frame
    add_req_checked(OP_WRITE, 32'h1234_5678, '0,
                    mk_result('0, 1'b0, 1'b0, EV_NONE, '0, 17'd1, 1'b0));
    add_req_checked(OP_WRITE, 32'hA5A5_A5A5, 17'd1,
                    mk_result('0, 1'b0, 1'b1, EV_NONE, '0, 17'd2, 1'b0));
    // frames that just fit, then one four words too long
    add_req(OP_WRITE, 32'h0000_0000, 17'd65534);
    add_req(OP_WRITE, 32'h8000_0001, 17'd65533);
    add_req(OP_WRITE, 32'h7FFF_FFFE, 17'h10000);
    // below the reset prebuffer level: silence while stopped
    add_req(OP_PLAY, 32'h0, 17'h0);
    add_cfg(17'd0);
    add_req_checked(OP_PLAY, 32'h0, 17'h0,
                    mk_result(32'hFFFF_FFFF, 1'b1, 1'b0, EV_PRIMED, '0, 17'd3, 1'b1));
    add_req(OP_PLAY, 32'h0, 17'h0);
    add_req(OP_PLAY, 32'h0, 17'h0);
    add_req(OP_PLAY, 32'h0, 17'h0);
    // empty while running: underrun; then restart and underrun in one go
    add_req(OP_PLAY, 32'h0, 17'h0);
    add_req(OP_PLAY, 32'h0, 17'h0);
    // prebuffer level that can never be reached while input is live
    add_cfg(17'h1FFFF);
    add_req(OP_WRITE, 32'h0F0F_0F0F, 17'd2);
    add_req(OP_PLAY, 32'h0, 17'h0);
    head_rows = row_table.size();

    // Closing rows: end of input and what follows it
    add_cfg(17'h1FFFF);
    add_req(OP_WRITE, 32'hDEAD_BEEF, 17'd1);
    add_req(OP_PLAY, 32'h0, 17'h0);
    add_req(OP_END, 32'hFFFF_FFFF, 17'h1FFFF);
    add_req(OP_PLAY, 32'h0, 17'h0);
    add_req(OP_PLAY, 32'h0, 17'h0);
    add_req(OP_END, 32'h0, 17'h0);
    add_req(OP_WRITE, 32'hC3C3_3C3C, '0);
    add_req(OP_PLAY, 32'h0, 17'h0);

    // Hold reset, then release it on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_rows(0, head_rows - 1);

    // Small prebuffer, idling on both sides
    drain_results();
    set_prebuffer(17'd1);
    random_phase(110);

    // Back the block up: long receiver hold while requests keep coming
    drain_results();
    set_prebuffer(LEN_W'($urandom_range(2, 12)));
    tx_idle_on = 1'b0;
    hold_req   = 1'b1;
    random_phase(110);
    hold_req   = 1'b0;

    // Zero prebuffer, no idling anywhere
    drain_results();
    set_prebuffer(17'd0);
    rx_idle_on = 1'b0;
    random_phase(110);

    drain_results();
    set_prebuffer(LEN_W'($urandom_range(1, 6)));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    random_phase(110);

    run_rows(head_rows, row_table.size() - 1);

    // Input has ended for good: keep writing and playing
    drain_results();
    set_prebuffer(LEN_W'($urandom_range(1, 4)));
    random_phase(110);

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
